>>> sv/sdh_pkg.sv
// ---------------------------------------------------------------------------
// SD SPI host package
// Shared types, constants and codes for the SD-card SPI-mode host sequencer.
// ---------------------------------------------------------------------------
package sdh_pkg;

   localparam int SECTOR_BYTES = 512;
   localparam int WAKE_BYTES   = 10;
   localparam int CNT_W        = $clog2(SECTOR_BYTES + 1);

   typedef enum logic [2:0] {
      OP_INIT  = 3'd0,
      OP_READ  = 3'd1,
      OP_WRITE = 3'd2,
      OP_RX    = 3'd3,
      OP_WBYTE = 3'd4,
      OP_TICK  = 3'd5
   } op_type;

   typedef enum logic [1:0] {
      KIND_XCHG  = 2'd0,
      KIND_RDATA = 2'd1,
      KIND_NEEDW = 2'd2,
      KIND_DONE  = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      ST_OK  = 2'd0,
      ST_ERR = 2'd1,
      ST_TMO = 2'd2
   } status_type;

   typedef enum logic [3:0] {
      PH_IDLE, PH_WAKE, PH_READY, PH_FRAME, PH_POLL, PH_EXTRA, PH_TRAIL,
      PH_TOKEN, PH_RDATA, PH_RCRC, PH_WSTART, PH_WNEED, PH_WDATA, PH_WCRC,
      PH_WRESP, PH_WBUSY
   } phase_type;

   typedef enum logic [3:0] {
      ACT_NONE, ACT_CMD0, ACT_CMD8, ACT_CMD55, ACT_CMD41, ACT_CMD58,
      ACT_OK, ACT_ERR, ACT_TMO
   } act_type;

   localparam logic [1:0] REG_READY_TMO = 2'd0;
   localparam logic [1:0] REG_INIT_TMO  = 2'd1;
   localparam logic [1:0] REG_TOKEN_TMO = 2'd2;
   localparam logic [1:0] REG_POLLS     = 2'd3;

   localparam logic [7:0] BYTE_FF    = 8'hFF;
   localparam logic [7:0] TOKEN_DATA = 8'hFE;

   // Classified input word passed from the front to the back.
   typedef struct packed {
      op_type      op;
      logic [31:0] sector;
      logic [7:0]  data_byte;
   } cmd_type;

   // One result word.
   typedef struct packed {
      kind_type    kind;
      logic [7:0]  tx_byte;
      logic        chip_select_high;
      logic [7:0]  read_byte;
      status_type  status;
      logic        last;
   } rsp_type;

endpackage

>>> sv/sdh_if.sv
// ---------------------------------------------------------------------------
// SD SPI host channels
// Valid/ready channel interfaces for request, response and register writes.
// ---------------------------------------------------------------------------
interface sdh_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  operation;
   logic [31:0] sector;
   logic [7:0]  data_byte;
   modport source (output valid, operation, sector, data_byte, input ready);
   modport sink   (input valid, operation, sector, data_byte, output ready);
endinterface

interface sdh_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] kind;
   logic [7:0] tx_byte;
   logic       chip_select_high;
   logic [7:0] read_byte;
   logic [1:0] status;
   logic       last;
   modport source (output valid, kind, tx_byte, chip_select_high, read_byte,
                   status, last, input ready);
   modport sink   (input valid, kind, tx_byte, chip_select_high, read_byte,
                   status, last, output ready);
endinterface

interface sdh_csr_if;
   logic        valid;
   logic        ready;
   logic [1:0]  index;
   logic [15:0] data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

>>> sv/sdh_front.sv
// ---------------------------------------------------------------------------
// SD SPI host front end
// Accepts request words and queues them in a two-entry FIFO for the back end.
// ---------------------------------------------------------------------------
module sdh_front
   import sdh_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   sdh_req_if.sink req,
   output logic    cmd_valid,
   input  logic    cmd_ready,
   output cmd_type cmd
);

   cmd_type    fifo_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push, pop;

   // Operation codes six and seven are dropped here; they never reach the back.
   assign req.ready = (count_ff != 2'd2);
   assign push      = req.valid && req.ready && (req.operation <= 3'(OP_TICK));
   assign pop       = cmd_valid && cmd_ready;
   assign cmd_valid = (count_ff != 2'd0);
   assign cmd       = fifo_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         fifo_ff[wr_ptr_ff] <= '{op: op_type'(req.operation), sector: req.sector,
                                 data_byte: req.data_byte};
      end
   end

   // The queue never holds more than its two entries.
   a_count_max: assert property (@(posedge clock) disable iff (reset)
      count_ff != 2'd3) else $error("front queue overflow");
   // A full queue refuses new words.
   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      count_ff == 2'd2 |-> !req.ready) else $error("full queue took a word");
   // An empty queue shows no word.
   a_empty: assert property (@(posedge clock) disable iff (reset)
      count_ff == 2'd0 |-> !cmd_valid) else $error("empty queue valid");

endmodule

>>> sv/sdh_back.sv
// ---------------------------------------------------------------------------
// SD SPI host back end
// Runs the init, read and write sequences one word at a time and emits up to
// two result words per input word through a small output queue.
// ---------------------------------------------------------------------------
module sdh_back
   import sdh_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     cmd_valid,
   output logic     cmd_ready,
   input  cmd_type  cmd,
   sdh_csr_if.sink  csr,
   sdh_rsp_if.source rsp
);

   // Configuration registers.
   logic [15:0] ready_tmo_ff, init_tmo_ff, token_tmo_ff;
   logic [3:0]  polls_ff;

   // Sequencer state.
   phase_type   phase_ff, phase_in;
   act_type     act_ff, act_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [3:0]  poll_ff, poll_in;
   logic [15:0] elapsed_ff, elapsed_in;
   logic [15:0] loop_ff, loop_in;
   logic [47:0] frame_ff, frame_in;
   logic [7:0]  last_rsp_ff, last_rsp_in;
   logic [7:0]  extra_ff [4];
   logic        extra_we;
   logic [1:0]  extra_idx;

   // Results of the current word.
   rsp_type     res [2];
   logic [1:0]  res_n;

   // Output queue of four entries.
   rsp_type     oq_ff [4];
   logic [1:0]  oq_wr_ff, oq_rd_ff;
   logic [2:0]  oq_cnt_ff, oq_cnt_in;
   logic        take, pop;

   logic [5:0]  cmd_idx;
   logic [3:0]  polls_eff;
   logic [7:0]  rx;

   assign csr.ready = 1'b1;
   assign cmd_ready = (oq_cnt_ff <= 3'd2);
   assign take      = cmd_valid && cmd_ready;
   assign pop       = rsp.valid && rsp.ready;
   assign cmd_idx   = frame_ff[45:40];
   assign polls_eff = (polls_ff == 4'd0) ? 4'd1 : polls_ff;
   assign rx        = cmd.data_byte;

   // Sequencer next-state logic.
   always_comb begin
      logic [7:0] fb;
      phase_in    = phase_ff;
      act_in      = act_ff;
      cnt_in      = cnt_ff;
      poll_in     = poll_ff;
      elapsed_in  = elapsed_ff;
      loop_in     = loop_ff;
      frame_in    = frame_ff;
      last_rsp_in = last_rsp_ff;
      extra_we    = 1'b0;
      extra_idx   = cnt_ff[1:0];
      res_n       = 2'd0;
      res[0]      = '0;
      res[1]      = '0;
      fb          = 8'h00;

      if (take) begin
         case (cmd.op)
            OP_INIT: begin
               if (phase_ff == PH_IDLE) begin
                  phase_in = PH_WAKE;
                  cnt_in   = '0;
                  res_n    = 2'd1;
                  res[0]   = '{KIND_XCHG, BYTE_FF, 1'b1, 8'h00, ST_OK, 1'b0};
               end
            end
            OP_READ, OP_WRITE: begin
               if (phase_ff == PH_IDLE) begin
                  frame_in = (cmd.op == OP_READ) ?
                             {8'h51, cmd.sector, 8'hFF} : {8'h58, cmd.sector, 8'hFF};
                  elapsed_in = '0;
                  phase_in   = PH_READY;
                  res_n      = 2'd1;
                  res[0]     = '{KIND_XCHG, BYTE_FF, 1'b0, 8'h00, ST_OK, 1'b0};
               end
            end
            OP_WBYTE: begin
               if (phase_ff == PH_WNEED) begin
                  phase_in = PH_WDATA;
                  res_n    = 2'd1;
                  res[0]   = '{KIND_XCHG, rx, 1'b0, 8'h00, ST_OK, 1'b0};
               end
            end
            OP_TICK: begin
               if (elapsed_ff != 16'hFFFF) elapsed_in = elapsed_ff + 16'd1;
               if (loop_ff != 16'hFFFF) loop_in = loop_ff + 16'd1;
            end
            OP_RX: begin
               // Each branch sets at most one word in res[0], except read data.
               res_n  = 2'd1;
               res[0] = '{KIND_XCHG, BYTE_FF, 1'b0, 8'h00, ST_OK, 1'b0};
               case (phase_ff)
                  PH_WAKE: begin
                     cnt_in = cnt_ff + 1'b1;
                     if (cnt_in < CNT_W'(WAKE_BYTES)) begin
                        res[0].chip_select_high = 1'b1;
                     end else begin
                        frame_in = {8'h40, 32'h0, 8'h95};
                        elapsed_in = '0;
                        phase_in = PH_READY;
                     end
                  end
                  PH_READY: begin
                     if (rx != 8'h00 || elapsed_ff >= ready_tmo_ff) begin
                        phase_in = PH_FRAME;
                        cnt_in   = '0;
                        res[0].tx_byte = frame_ff[47:40];
                     end
                  end
                  PH_FRAME: begin
                     cnt_in = cnt_ff + 1'b1;
                     case (cnt_in[2:0])
                        3'd1: fb = frame_ff[39:32];
                        3'd2: fb = frame_ff[31:24];
                        3'd3: fb = frame_ff[23:16];
                        3'd4: fb = frame_ff[15:8];
                        3'd5: fb = frame_ff[7:0];
                        default: fb = BYTE_FF;
                     endcase
                     if (cnt_in < CNT_W'(6)) begin
                        res[0].tx_byte = fb;
                     end else begin
                        phase_in = PH_POLL;
                        poll_in  = '0;
                     end
                  end
                  PH_POLL: begin
                     last_rsp_in = rx;
                     poll_in     = poll_ff + 4'd1;
                     if (!rx[7] || poll_in >= polls_eff) begin
                        case (cmd_idx)
                           6'd0: begin
                              act_in = ACT_CMD0; phase_in = PH_TRAIL;
                              res[0].chip_select_high = 1'b1;
                           end
                           6'd8: begin
                              if (rx == 8'h01) begin
                                 phase_in = PH_EXTRA; cnt_in = '0;
                              end else begin
                                 phase_in = PH_IDLE;
                                 res[0] = '{KIND_DONE, 8'h00, 1'b0, 8'h00, ST_ERR, 1'b0};
                              end
                           end
                           6'd55: begin
                              act_in = ACT_CMD55; phase_in = PH_TRAIL;
                              res[0].chip_select_high = 1'b1;
                           end
                           6'd41: begin
                              act_in = ACT_CMD41; phase_in = PH_TRAIL;
                              res[0].chip_select_high = 1'b1;
                           end
                           6'd58: begin
                              phase_in = PH_EXTRA; cnt_in = '0;
                           end
                           6'd17: begin
                              if (rx != 8'h00) begin
                                 act_in = ACT_ERR; phase_in = PH_TRAIL;
                                 res[0].chip_select_high = 1'b1;
                              end else begin
                                 phase_in = PH_TOKEN; elapsed_in = '0;
                              end
                           end
                           default: begin
                              if (rx != 8'h00) begin
                                 act_in = ACT_ERR; phase_in = PH_TRAIL;
                                 res[0].chip_select_high = 1'b1;
                              end else begin
                                 phase_in = PH_WSTART;
                                 res[0].tx_byte = TOKEN_DATA;
                              end
                           end
                        endcase
                     end
                  end
                  PH_EXTRA: begin
                     extra_we = 1'b1;
                     cnt_in   = cnt_ff + 1'b1;
                     if (cnt_in >= CNT_W'(4)) begin
                        act_in = (cmd_idx == 6'd8) ? ACT_CMD8 : ACT_CMD58;
                        phase_in = PH_TRAIL;
                        res[0].chip_select_high = 1'b1;
                     end
                  end
                  PH_TRAIL: begin
                     // Ends the trailer: either launch the next command or finish.
                     res[0] = '{KIND_DONE, 8'h00, 1'b0, 8'h00, ST_ERR, 1'b0};
                     phase_in = PH_IDLE;
                     case (act_ff)
                        ACT_CMD0: begin
                           if (last_rsp_ff == 8'h01) begin
                              frame_in = {8'h48, 32'h000001AA, 8'h87};
                              elapsed_in = '0; phase_in = PH_READY;
                              res[0] = '{KIND_XCHG, BYTE_FF, 1'b0, 8'h00, ST_OK, 1'b0};
                           end
                        end
                        ACT_CMD8: begin
                           if (extra_ff[3] == 8'hAA && extra_ff[2][3:0] == 4'h1) begin
                              loop_in = '0;
                              frame_in = {8'h77, 32'h0, 8'h65};
                              elapsed_in = '0; phase_in = PH_READY;
                              res[0] = '{KIND_XCHG, BYTE_FF, 1'b0, 8'h00, ST_OK, 1'b0};
                           end
                        end
                        ACT_CMD55: begin
                           frame_in = {8'h69, 32'h40000000, 8'h77};
                           elapsed_in = '0; phase_in = PH_READY;
                           res[0] = '{KIND_XCHG, BYTE_FF, 1'b0, 8'h00, ST_OK, 1'b0};
                        end
                        ACT_CMD41: begin
                           if (last_rsp_ff == 8'h00) begin
                              frame_in = {8'h7A, 32'h0, 8'hFD};
                              elapsed_in = '0; phase_in = PH_READY;
                              res[0] = '{KIND_XCHG, BYTE_FF, 1'b0, 8'h00, ST_OK, 1'b0};
                           end else if (loop_ff < init_tmo_ff) begin
                              frame_in = {8'h77, 32'h0, 8'h65};
                              elapsed_in = '0; phase_in = PH_READY;
                              res[0] = '{KIND_XCHG, BYTE_FF, 1'b0, 8'h00, ST_OK, 1'b0};
                           end else begin
                              res[0].status = ST_TMO;
                           end
                        end
                        ACT_CMD58: begin
                           if (last_rsp_ff == 8'h00 && extra_ff[0][6]) res[0].status = ST_OK;
                        end
                        ACT_OK:  res[0].status = ST_OK;
                        ACT_TMO: res[0].status = ST_TMO;
                        default: res[0].status = ST_ERR;
                     endcase
                  end
                  PH_TOKEN: begin
                     if (rx == TOKEN_DATA) begin
                        phase_in = PH_RDATA; cnt_in = '0;
                     end else if (elapsed_ff >= token_tmo_ff) begin
                        act_in = ACT_TMO; phase_in = PH_TRAIL;
                        res[0].chip_select_high = 1'b1;
                     end
                  end
                  PH_RDATA: begin
                     res_n  = 2'd2;
                     res[0] = '{KIND_RDATA, 8'h00, 1'b0, rx, ST_OK, 1'b0};
                     res[1] = '{KIND_XCHG, BYTE_FF, 1'b0, 8'h00, ST_OK, 1'b0};
                     cnt_in = cnt_ff + 1'b1;
                     if (cnt_in >= CNT_W'(SECTOR_BYTES)) begin
                        phase_in = PH_RCRC; cnt_in = '0;
                     end
                  end
                  PH_RCRC: begin
                     cnt_in = cnt_ff + 1'b1;
                     if (cnt_in >= CNT_W'(2)) begin
                        act_in = ACT_OK; phase_in = PH_TRAIL;
                        res[0].chip_select_high = 1'b1;
                     end
                  end
                  PH_WSTART: begin
                     phase_in = PH_WNEED; cnt_in = '0;
                     res[0] = '{KIND_NEEDW, 8'h00, 1'b0, 8'h00, ST_OK, 1'b0};
                  end
                  PH_WDATA: begin
                     cnt_in = cnt_ff + 1'b1;
                     if (cnt_in < CNT_W'(SECTOR_BYTES)) begin
                        phase_in = PH_WNEED;
                        res[0] = '{KIND_NEEDW, 8'h00, 1'b0, 8'h00, ST_OK, 1'b0};
                     end else begin
                        phase_in = PH_WCRC; cnt_in = '0;
                     end
                  end
                  PH_WCRC: begin
                     cnt_in = cnt_ff + 1'b1;
                     if (cnt_in >= CNT_W'(2)) phase_in = PH_WRESP;
                  end
                  PH_WRESP: begin
                     if (rx[4:0] != 5'h05) begin
                        act_in = ACT_ERR; phase_in = PH_TRAIL;
                        res[0].chip_select_high = 1'b1;
                     end else begin
                        phase_in = PH_WBUSY; elapsed_in = '0;
                     end
                  end
                  PH_WBUSY: begin
                     if (rx != 8'h00) begin
                        act_in = ACT_OK; phase_in = PH_TRAIL;
                        res[0].chip_select_high = 1'b1;
                     end else if (elapsed_ff >= ready_tmo_ff) begin
                        phase_in = PH_IDLE;
                        res[0] = '{KIND_DONE, 8'h00, 1'b0, 8'h00, ST_TMO, 1'b0};
                     end
                  end
                  default: res_n = 2'd0;
               endcase
            end
            default: res_n = 2'd0;
         endcase
      end
      if (res_n == 2'd1) res[0].last = 1'b1;
      if (res_n == 2'd2) res[1].last = 1'b1;
   end

   // Sequencer state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_IDLE;
         act_ff      <= ACT_NONE;
         cnt_ff      <= '0;
         poll_ff     <= '0;
         elapsed_ff  <= '0;
         loop_ff     <= '0;
         frame_ff    <= '0;
         last_rsp_ff <= 8'hFF;
      end else begin
         phase_ff    <= phase_in;
         act_ff      <= act_in;
         cnt_ff      <= cnt_in;
         poll_ff     <= poll_in;
         elapsed_ff  <= elapsed_in;
         loop_ff     <= loop_in;
         frame_ff    <= frame_in;
         last_rsp_ff <= last_rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (extra_we) extra_ff[extra_idx] <= rx;
   end

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         ready_tmo_ff <= 16'd500;
         init_tmo_ff  <= 16'd1000;
         token_tmo_ff <= 16'd200;
         polls_ff     <= 4'd8;
      end else if (csr.valid) begin
         case (csr.index)
            REG_READY_TMO: ready_tmo_ff <= csr.data;
            REG_INIT_TMO:  init_tmo_ff  <= csr.data;
            REG_TOKEN_TMO: token_tmo_ff <= csr.data;
            REG_POLLS:     polls_ff     <= csr.data[3:0];
            default:       polls_ff     <= polls_ff;
         endcase
      end
   end

   // Output queue.
   assign oq_cnt_in = oq_cnt_ff + {1'b0, res_n} - {2'b00, pop};

   always_ff @(posedge clock) begin
      if (reset) begin
         oq_wr_ff  <= '0;
         oq_rd_ff  <= '0;
         oq_cnt_ff <= '0;
      end else begin
         oq_wr_ff  <= oq_wr_ff + res_n;
         oq_rd_ff  <= oq_rd_ff + {1'b0, pop};
         oq_cnt_ff <= oq_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res_n != 2'd0) oq_ff[oq_wr_ff] <= res[0];
      if (res_n == 2'd2) oq_ff[oq_wr_ff + 2'd1] <= res[1];
   end

   assign rsp.valid            = (oq_cnt_ff != 3'd0);
   assign rsp.kind             = oq_ff[oq_rd_ff].kind;
   assign rsp.tx_byte          = oq_ff[oq_rd_ff].tx_byte;
   assign rsp.chip_select_high = oq_ff[oq_rd_ff].chip_select_high;
   assign rsp.read_byte        = oq_ff[oq_rd_ff].read_byte;
   assign rsp.status           = oq_ff[oq_rd_ff].status;
   assign rsp.last             = oq_ff[oq_rd_ff].last;

   // The output queue never exceeds four words.
   a_oq_max: assert property (@(posedge clock) disable iff (reset)
      oq_cnt_ff <= 3'd4) else $error("output queue overflow");
   // A done word always returns the sequencer to idle.
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      take && res_n != 2'd0 && res[0].kind == KIND_DONE |=> phase_ff == PH_IDLE)
      else $error("done without idle");
   // Two results only come from the read data phase.
   a_two_rdata: assert property (@(posedge clock) disable iff (reset)
      res_n == 2'd2 |-> phase_ff == PH_RDATA) else $error("stray double result");
   // Nothing is produced without an accepted word.
   a_no_invent: assert property (@(posedge clock) disable iff (reset)
      !take |-> res_n == 2'd0) else $error("result without input");

endmodule

>>> sv/sd_spi_host_sequencer_top.sv
// ---------------------------------------------------------------------------
// SD SPI host sequencer top level
// Connects the request front end and the sequencing back end.
// ---------------------------------------------------------------------------
// Path: a result is written into the output queue by the sequencer step that takes
// its word from the front queue; a read data byte brings two words.
// Throughput: one input word per cycle while the output queue has room.
// Reset: synchronous, active high; registers return to their defaults and the
// sequencer to idle.
module sd_spi_host_sequencer_top
   import sdh_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   sdh_req_if.sink   req,
   sdh_rsp_if.source rsp,
   sdh_csr_if.sink   csr
);

   logic    cmd_valid, cmd_ready;
   cmd_type cmd;

   sdh_front u_front (
      .clock, .reset, .req, .cmd_valid, .cmd_ready, .cmd
   );

   sdh_back u_back (
      .clock, .reset, .cmd_valid, .cmd_ready, .cmd, .csr, .rsp
   );

endmodule

>>> test/sdh_checker.sv
// ---------------------------------------------------------------------------
// SD SPI host sequencer checker
// Watches the request, response and register channels, predicts every
// response word of the sequencer and compares it field by field.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module sdh_checker
   import sdh_pkg::*;
(
   input  logic  clock,
   input  logic  reset,
   sdh_req_if    req,
   sdh_rsp_if    rsp,
   sdh_csr_if    csr,
   output int    mismatches,
   output int    pending,
   output logic  card_idle
);

   // SD command numbers and fixed frame contents.
   localparam logic [5:0]  CMD_GO_IDLE   = 6'd0;
   localparam logic [5:0]  CMD_IF_COND   = 6'd8;
   localparam logic [5:0]  CMD_READ_ONE  = 6'd17;
   localparam logic [5:0]  CMD_WRITE_ONE = 6'd24;
   localparam logic [5:0]  CMD_OP_COND   = 6'd41;
   localparam logic [5:0]  CMD_APP       = 6'd55;
   localparam logic [5:0]  CMD_READ_OCR  = 6'd58;
   localparam logic [7:0]  CRC_GO_IDLE   = 8'h95;
   localparam logic [7:0]  CRC_IF_COND   = 8'h87;
   localparam logic [7:0]  CRC_APP       = 8'h65;
   localparam logic [7:0]  CRC_OP_COND   = 8'h77;
   localparam logic [7:0]  CRC_READ_OCR  = 8'hFD;
   localparam logic [31:0] ARG_IF_COND   = 32'h0000_01AA;
   localparam logic [31:0] ARG_HCS       = 32'h4000_0000;
   localparam logic [7:0]  R1_IDLE       = 8'h01;
   localparam logic [7:0]  ECHO_PATTERN  = 8'hAA;
   localparam logic [4:0]  DRESP_OK      = 5'h05;

   // Register copies.
   logic [15:0] ready_limit, init_limit, token_limit;
   logic [3:0]  poll_limit;

   // Sequencer state copy.
   phase_type   phase;
   act_type     trail_act;
   logic [9:0]  byte_cnt;
   logic [3:0]  poll_cnt;
   logic [15:0] elapsed, loop_ms;
   logic [47:0] frame;
   logic [31:0] block_addr;
   logic [7:0]  r1;
   logic [7:0]  extra_bytes [4];

   rsp_type     step_words [2];
   int          step_count;
   rsp_type     expected_words [$];

   assign card_idle = (phase == PH_IDLE);

   task report_mismatch(input string msg);
      $display("%0t: response mismatch: %s", $time, msg);
      mismatches++;
   endtask

   task check_field(input string name, input int got, input int want);
      if (got != want)
         report_mismatch($sformatf("%s expected %0d got %0d", name, want, got));
   endtask

   task emit(input kind_type k, input logic [7:0] tx, input logic cs,
             input logic [7:0] rb, input status_type st);
      rsp_type w;
      if (step_count < 2) begin
         w = '0;
         w.kind = k;
         w.tx_byte = tx;
         w.chip_select_high = cs;
         w.read_byte = rb;
         w.status = st;
         step_words[step_count] = w;
         step_count++;
      end
   endtask

   task exchange(input logic [7:0] tx, input logic cs);
      emit(KIND_XCHG, tx, cs, 8'h00, ST_OK);
   endtask

   task finish_job(input status_type st);
      phase = PH_IDLE;
      emit(KIND_DONE, 8'h00, 1'b0, 8'h00, st);
   endtask

   task begin_trailer(input act_type a);
      trail_act = a;
      phase = PH_TRAIL;
      exchange(BYTE_FF, 1'b1);
   endtask

   task begin_command(input logic [5:0] cmd, input logic [31:0] arg,
                      input logic [7:0] crc);
      frame = {2'b01, cmd, arg, crc};
      elapsed = '0;
      phase = PH_READY;
      exchange(BYTE_FF, 1'b0);
   endtask

   task send_frame_byte;
      exchange(frame[47 - 8 * byte_cnt -: 8], 1'b0);
   endtask

   task start_extra;
      phase = PH_EXTRA;
      byte_cnt = '0;
      exchange(BYTE_FF, 1'b0);
   endtask

   // The R1 answer decides the next step per command.
   task after_response;
      case (frame[45:40])
         CMD_GO_IDLE: begin_trailer(ACT_CMD0);
         CMD_IF_COND: begin
            if (r1 == R1_IDLE) start_extra();
            else finish_job(ST_ERR);
         end
         CMD_APP:      begin_trailer(ACT_CMD55);
         CMD_OP_COND:  begin_trailer(ACT_CMD41);
         CMD_READ_OCR: start_extra();
         CMD_READ_ONE: begin
            if (r1 != 8'h00) begin_trailer(ACT_ERR);
            else begin
               phase = PH_TOKEN;
               elapsed = '0;
               exchange(BYTE_FF, 1'b0);
            end
         end
         default: begin
            if (r1 != 8'h00) begin_trailer(ACT_ERR);
            else begin
               phase = PH_WSTART;
               exchange(TOKEN_DATA, 1'b0);
            end
         end
      endcase
   endtask

   // The trailing exchange has come back: move on or end the job.
   task after_trailer;
      case (trail_act)
         ACT_CMD0: begin
            if (r1 == R1_IDLE) begin_command(CMD_IF_COND, ARG_IF_COND, CRC_IF_COND);
            else finish_job(ST_ERR);
         end
         ACT_CMD8: begin
            if (extra_bytes[3] == ECHO_PATTERN && extra_bytes[2][3:0] == 4'h1) begin
               loop_ms = '0;
               begin_command(CMD_APP, 32'h0, CRC_APP);
            end else finish_job(ST_ERR);
         end
         ACT_CMD55: begin_command(CMD_OP_COND, ARG_HCS, CRC_OP_COND);
         ACT_CMD41: begin
            if (r1 == 8'h00) begin_command(CMD_READ_OCR, 32'h0, CRC_READ_OCR);
            else if (loop_ms < init_limit) begin_command(CMD_APP, 32'h0, CRC_APP);
            else finish_job(ST_TMO);
         end
         ACT_CMD58: begin
            if (r1 == 8'h00 && extra_bytes[0][6]) finish_job(ST_OK);
            else finish_job(ST_ERR);
         end
         ACT_OK:  finish_job(ST_OK);
         ACT_TMO: finish_job(ST_TMO);
         default: finish_job(ST_ERR);
      endcase
   endtask

   // A byte returned by the card, handled according to the current phase.
   task on_card_byte(input logic [7:0] rx);
      logic [3:0] polls;
      polls = (poll_limit == 4'd0) ? 4'd1 : poll_limit;
      case (phase)
         PH_WAKE: begin
            byte_cnt++;
            if (byte_cnt < WAKE_BYTES) exchange(BYTE_FF, 1'b1);
            else begin_command(CMD_GO_IDLE, 32'h0, CRC_GO_IDLE);
         end
         PH_READY: begin
            if (rx != 8'h00 || elapsed >= ready_limit) begin
               phase = PH_FRAME;
               byte_cnt = '0;
               send_frame_byte();
            end else exchange(BYTE_FF, 1'b0);
         end
         PH_FRAME: begin
            byte_cnt++;
            if (byte_cnt < 6) send_frame_byte();
            else begin
               phase = PH_POLL;
               poll_cnt = '0;
               exchange(BYTE_FF, 1'b0);
            end
         end
         PH_POLL: begin
            r1 = rx;
            poll_cnt++;
            if (!rx[7] || poll_cnt >= polls) after_response();
            else exchange(BYTE_FF, 1'b0);
         end
         PH_EXTRA: begin
            extra_bytes[byte_cnt[1:0]] = rx;
            byte_cnt++;
            if (byte_cnt < 4) exchange(BYTE_FF, 1'b0);
            else if (frame[45:40] == CMD_IF_COND) begin_trailer(ACT_CMD8);
            else begin_trailer(ACT_CMD58);
         end
         PH_TRAIL: after_trailer();
         PH_TOKEN: begin
            if (rx == TOKEN_DATA) begin
               phase = PH_RDATA;
               byte_cnt = '0;
               exchange(BYTE_FF, 1'b0);
            end else if (elapsed < token_limit) exchange(BYTE_FF, 1'b0);
            else begin_trailer(ACT_TMO);
         end
         PH_RDATA: begin
            emit(KIND_RDATA, 8'h00, 1'b0, rx, ST_OK);
            byte_cnt++;
            if (byte_cnt >= SECTOR_BYTES) begin
               phase = PH_RCRC;
               byte_cnt = '0;
            end
            exchange(BYTE_FF, 1'b0);
         end
         PH_RCRC: begin
            byte_cnt++;
            if (byte_cnt < 2) exchange(BYTE_FF, 1'b0);
            else begin_trailer(ACT_OK);
         end
         PH_WSTART: begin
            phase = PH_WNEED;
            byte_cnt = '0;
            emit(KIND_NEEDW, 8'h00, 1'b0, 8'h00, ST_OK);
         end
         PH_WDATA: begin
            byte_cnt++;
            if (byte_cnt < SECTOR_BYTES) begin
               phase = PH_WNEED;
               emit(KIND_NEEDW, 8'h00, 1'b0, 8'h00, ST_OK);
            end else begin
               phase = PH_WCRC;
               byte_cnt = '0;
               exchange(BYTE_FF, 1'b0);
            end
         end
         PH_WCRC: begin
            byte_cnt++;
            if (byte_cnt >= 2) phase = PH_WRESP;
            exchange(BYTE_FF, 1'b0);
         end
         PH_WRESP: begin
            if (rx[4:0] != DRESP_OK) begin_trailer(ACT_ERR);
            else begin
               phase = PH_WBUSY;
               elapsed = '0;
               exchange(BYTE_FF, 1'b0);
            end
         end
         PH_WBUSY: begin
            if (rx != 8'h00) begin_trailer(ACT_OK);
            else if (elapsed < ready_limit) exchange(BYTE_FF, 1'b0);
            else finish_job(ST_TMO);
         end
         default: ;
      endcase
   endtask

   // One accepted request word; its results go to the expected store.
   task step_word(input logic [2:0] op, input logic [31:0] sec, input logic [7:0] db);
      step_count = 0;
      case (op)
         OP_INIT: begin
            if (phase == PH_IDLE) begin
               phase = PH_WAKE;
               byte_cnt = '0;
               exchange(BYTE_FF, 1'b1);
            end
         end
         OP_READ, OP_WRITE: begin
            if (phase == PH_IDLE) begin
               block_addr = sec;
               begin_command(op == OP_READ ? CMD_READ_ONE : CMD_WRITE_ONE,
                             block_addr, BYTE_FF);
            end
         end
         OP_RX: if (phase != PH_IDLE && phase != PH_WNEED) on_card_byte(db);
         OP_WBYTE: begin
            if (phase == PH_WNEED) begin
               phase = PH_WDATA;
               exchange(db, 1'b0);
            end
         end
         OP_TICK: begin
            if (elapsed != 16'hFFFF) elapsed++;
            if (loop_ms != 16'hFFFF) loop_ms++;
         end
         default: ;
      endcase
      for (int k = 0; k < step_count; k++) begin
         step_words[k].last = (k == step_count - 1);
         expected_words.push_back(step_words[k]);
      end
   endtask

   // Per edge: compare any delivered word, then track writes and requests.
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         ready_limit = 16'd500;
         init_limit  = 16'd1000;
         token_limit = 16'd200;
         poll_limit  = 4'd8;
         phase = PH_IDLE;
         trail_act = ACT_NONE;
         byte_cnt = '0;
         poll_cnt = '0;
         elapsed = '0;
         loop_ms = '0;
         frame = '0;
         block_addr = '0;
         r1 = 8'hFF;
         for (int k = 0; k < 4; k++) extra_bytes[k] = 8'h00;
         expected_words.delete();
      end else begin
         if (rsp.valid && rsp.ready) begin
            if (expected_words.size() == 0)
               report_mismatch("word delivered with nothing expected");
            else begin
               want = expected_words.pop_front();
               check_field("kind", rsp.kind, want.kind);
               check_field("tx_byte", rsp.tx_byte, want.tx_byte);
               check_field("chip_select_high", rsp.chip_select_high,
                           want.chip_select_high);
               check_field("read_byte", rsp.read_byte, want.read_byte);
               check_field("status", rsp.status, want.status);
               check_field("last", rsp.last, want.last);
            end
         end
         if (csr.valid && csr.ready) begin
            case (csr.index)
               REG_READY_TMO: ready_limit = csr.data;
               REG_INIT_TMO:  init_limit  = csr.data;
               REG_TOKEN_TMO: token_limit = csr.data;
               REG_POLLS:     poll_limit  = csr.data[3:0];
               default: ;
            endcase
         end
         if (req.valid && req.ready)
            step_word(req.operation, req.sector, req.data_byte);
      end
      pending = expected_words.size();
   end

   initial begin
      mismatches = 0;
      pending = 0;
   end

endmodule

>>> test/sd_spi_host_sequencer_top_test.sv
// ---------------------------------------------------------------------------
// SD SPI host sequencer testbench
// Plays an SD card at the byte level through init, read and write jobs with
// random content, errors and timeouts, under several register settings and
// random idling on both sides; a checker predicts and compares every word.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module sd_spi_host_sequencer_top_test;
   import sdh_pkg::*;

   localparam int STALL_LIMIT = 3000;
   localparam int LONG_HOLD   = 400;

   logic clock = 1'b0;
   logic reset;
   int   mismatches, pending;
   logic card_idle;
   int   items_sent = 0;
   bit   sender_burst = 0;

   sdh_req_if req();
   sdh_rsp_if rsp();
   sdh_csr_if csr();

   sd_spi_host_sequencer_top u_top (
      .clock (clock),
      .reset (reset),
      .req   (req),
      .rsp   (rsp),
      .csr   (csr)
   );

   sdh_checker u_checker (
      .clock      (clock),
      .reset      (reset),
      .req        (req),
      .rsp        (rsp),
      .csr        (csr),
      .mismatches (mismatches),
      .pending    (pending),
      .card_idle  (card_idle)
   );

   always #6 clock = ~clock;

   // Offer one request word after a random gap and wait for it to be taken.
   task send_word(input logic [2:0] op, input logic [31:0] sec, input logic [7:0] db);
      int gap;
      gap = sender_burst ? 0 : $urandom_range(0, 10);
      if (gap != 0) begin
         req.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req.valid     <= 1'b1;
      req.operation <= op;
      req.sector    <= sec;
      req.data_byte <= db;
      do @(posedge clock); while (!req.ready);
      items_sent++;
      if ($urandom_range(0, 63) == 0) sender_burst = !sender_burst;
   endtask

   // A card byte, sometimes preceded by a millisecond tick.
   task card_byte(input logic [7:0] b);
      if ($urandom_range(0, 11) == 0) send_word(OP_TICK, $urandom, 8'($urandom));
      send_word(OP_RX, $urandom, b);
   endtask

   // Busy bytes, the six frame slots, a few filler polls and the R1 answer.
   task card_command(input logic [7:0] r1);
      repeat ($urandom_range(0, 2)) card_byte(8'h00);
      card_byte(8'($urandom_range(1, 255)));
      repeat (6) card_byte(8'($urandom));
      repeat ($urandom_range(0, 2)) card_byte(8'h80 | 8'($urandom));
      card_byte(r1);
   endtask

   function automatic logic [7:0] maybe_bad(input logic [7:0] good);
      return ($urandom_range(0, 5) == 0) ? 8'($urandom) : good;
   endfunction

   // Let the sequencer finish its job, feeding it card-like noise.
   task wait_card_idle;
      req.valid <= 1'b0;
      @(negedge clock);
      while (!card_idle) begin
         @(posedge clock);
         case ($urandom_range(0, 7))
            0: send_word(OP_TICK, $urandom, 8'($urandom));
            1: send_word(OP_WBYTE, $urandom, 8'($urandom));
            2: send_word(OP_RX, $urandom, 8'h00);
            3: send_word(OP_RX, $urandom, BYTE_FF);
            4: send_word(OP_RX, $urandom, TOKEN_DATA);
            5: send_word(OP_RX, $urandom, 8'h05);
            default: send_word(OP_RX, $urandom, 8'($urandom));
         endcase
         req.valid <= 1'b0;
         @(negedge clock);
      end
      @(posedge clock);
   endtask

   task run_init;
      int loops;
      wait_card_idle();
      send_word(OP_INIT, $urandom, 8'($urandom));
      repeat (WAKE_BYTES) card_byte(8'($urandom));
      card_command(maybe_bad(8'h01));
      card_byte(8'($urandom));
      card_command(maybe_bad(8'h01));
      card_byte(8'($urandom));
      card_byte(8'($urandom));
      card_byte(maybe_bad(8'h01 | (8'($urandom) & 8'hF0)));
      card_byte(maybe_bad(8'hAA));
      card_byte(8'($urandom));
      loops = $urandom_range(0, 3);
      for (int k = 0; k <= loops; k++) begin
         card_command(8'h01);
         card_byte(8'($urandom));
         card_command(k == loops ? maybe_bad(8'h00) : 8'h01);
         card_byte(8'($urandom));
      end
      card_command(maybe_bad(8'h00));
      card_byte(maybe_bad(8'h40 | 8'($urandom)));
      repeat (3) card_byte(8'($urandom));
      card_byte(8'($urandom));
   endtask

   // A full read moves a whole sector; a short one is refused by the card.
   task run_read(input logic [31:0] sec, input bit full);
      wait_card_idle();
      send_word(OP_READ, sec, 8'($urandom));
      if (!full) begin
         card_command(8'($urandom_range(1, 255)));
         card_byte(8'($urandom));
         return;
      end
      card_command(8'h00);
      repeat ($urandom_range(0, 3)) card_byte(BYTE_FF);
      card_byte(TOKEN_DATA);
      repeat (SECTOR_BYTES) card_byte(8'($urandom));
      repeat (3) card_byte(8'($urandom));
   endtask

   // A full write moves a whole sector; a short one is refused by the card.
   task run_write(input logic [31:0] sec, input bit full);
      wait_card_idle();
      send_word(OP_WRITE, sec, 8'($urandom));
      if (!full) begin
         card_command(8'($urandom_range(1, 255)));
         card_byte(8'($urandom));
         return;
      end
      card_command(8'h00);
      card_byte(8'($urandom));
      repeat (SECTOR_BYTES) begin
         send_word(OP_WBYTE, $urandom, 8'($urandom));
         card_byte(8'($urandom));
      end
      repeat (2) card_byte(8'($urandom));
      card_byte(maybe_bad({3'($urandom), 5'h05}));
      repeat ($urandom_range(0, 3)) card_byte(8'h00);
      card_byte(8'($urandom_range(1, 255)));
      card_byte(8'($urandom));
   endtask

   // Registers change only with the sequencer idle and every word delivered.
   task load_settings(input logic [15:0] ready_ms, input logic [15:0] init_ms,
                      input logic [15:0] token_ms, input logic [15:0] polls);
      logic [15:0] vals [4];
      vals = '{ready_ms, init_ms, token_ms, polls};
      wait_card_idle();
      req.valid <= 1'b0;
      @(negedge clock);
      while (pending != 0) @(negedge clock);
      repeat (10) @(posedge clock);
      for (int k = 0; k < 4; k++) begin
         csr.valid <= 1'b1;
         csr.index <= 2'(k);
         csr.data  <= vals[k];
         do @(posedge clock); while (!csr.ready);
      end
      csr.valid <= 1'b0;
   endtask

   // Receiver: random stalls, bursts without stalls and one long hold-off.
   initial begin
      int  gap, taken;
      bit  burst, held;
      taken = 0;
      burst = 0;
      held = 0;
      forever begin
         if (!held && taken >= 40) begin
            rsp.ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
            held = 1;
         end
         gap = burst ? 0 : $urandom_range(0, 10);
         if (gap != 0) begin
            rsp.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp.ready <= 1'b1;
         do @(posedge clock); while (!rsp.valid);
         taken++;
         if ($urandom_range(0, 63) == 0) burst = !burst;
      end
   end

   // Watchdog on cycles in which no channel moves a word.
   initial begin
      int stalled;
      stalled = 0;
      forever begin
         @(posedge clock);
         if (reset || (req.valid && req.ready) || (rsp.valid && rsp.ready) ||
             (csr.valid && csr.ready))
            stalled = 0;
         else
            stalled++;
         if (stalled >= STALL_LIMIT) begin
            $display("sd_spi_host_sequencer_top_test: FAIL");
            $finish;
         end
      end
   end

   // Stimulus and verdict.
   initial begin
      int waited;
      reset         <= 1'b1;
      req.valid     <= 1'b0;
      req.operation <= OP_TICK;
      req.sector    <= '0;
      req.data_byte <= '0;
      csr.valid     <= 1'b0;
      csr.index     <= REG_READY_TMO;
      csr.data      <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: undefined operations and words that arrive out of turn.
      send_word(3'd6, 32'h0, 8'h00);
      send_word(3'd7, 32'hFFFF_FFFF, 8'hFF);
      send_word(OP_RX, $urandom, 8'hFF);
      send_word(OP_WBYTE, $urandom, 8'h00);
      send_word(OP_TICK, $urandom, 8'($urandom));
      send_word(OP_INIT, $urandom, 8'($urandom));
      send_word(OP_INIT, $urandom, 8'($urandom));
      send_word(OP_READ, 32'hFFFF_FFFF, 8'($urandom));
      send_word(OP_WRITE, 32'h0, 8'($urandom));

      // One whole sector each way under the default registers.
      run_read(32'hFFFF_FFFF, 1'b1);
      run_write(32'h0, 1'b1);

      // One random job under each of a series of register settings.
      for (int s = 1; s < 6; s++) begin
         case (s)
            1: load_settings(16'd0, 16'd0, 16'd0, 16'd0);
            2: load_settings(16'd1, 16'd1, 16'd1, 16'd1);
            3: load_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd15);
            4: load_settings(16'($urandom_range(1, 30)), 16'($urandom_range(1, 30)),
                             16'($urandom_range(1, 30)), 16'($urandom_range(1, 15)));
            default: load_settings(16'($urandom), 16'($urandom), 16'($urandom),
                                   16'($urandom));
         endcase
         case ($urandom_range(0, 3))
            0, 1:    run_init();
            2:       run_read($urandom, 1'b0);
            default: run_write($urandom, 1'b0);
         endcase
      end
      wait_card_idle();
      req.valid <= 1'b0;

      // Drain: every expected word must arrive.
      waited = 0;
      @(negedge clock);
      while (pending != 0 && waited < 20000) begin
         @(negedge clock);
         waited++;
      end
      repeat (20) @(posedge clock);
      if (pending == 0 && mismatches == 0)
         $display("sd_spi_host_sequencer_top_test: PASS");
      else
         $display("sd_spi_host_sequencer_top_test: FAIL");
      $finish;
   end

endmodule

>>> sim.f
sv/sdh_pkg.sv
sv/sdh_if.sv
sv/sdh_front.sv
sv/sdh_back.sv
sv/sd_spi_host_sequencer_top.sv
test/sdh_checker.sv
test/sd_spi_host_sequencer_top_test.sv
